FILE: rtl/core/ufpq_pkg.sv
package ufpq_pkg;

  localparam int CAPACITY_DEF = 64;

  // result status codes
  localparam logic [1:0] STAT_ADDED      = 2'd0;
  localparam logic [1:0] STAT_DISPATCHED = 2'd1;
  localparam logic [1:0] STAT_EMPTY      = 2'd2;
  localparam logic [1:0] STAT_FULL       = 2'd3;

  // action codes
  localparam logic ACT_ADD      = 1'b0;
  localparam logic ACT_DISPATCH = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD_SCAN,
    S_DSP_SCAN,
    S_DSP_DONE
  } state_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] tag;
    logic [15:0] item_ref;
    logic [15:0] address_ref;
    logic [1:0]  urgency;
    logic [31:0] stamp;
  } slot_t;

endpackage

FILE: rtl/core/ufpq_ram.sv
module ufpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/urgency_fifo_priority_queue.sv
// Channel   Ports                                              Transfer
// -------   -------------------------------------------------  ------------------------
// input     start, busy, in_action, in_tag, in_item_ref,       edge with start && !busy
//           in_address_ref, in_urgency
// result    out_valid, out_status, out_tag, out_item_ref,      edge ending a cycle
//           out_address_ref, out_urgency, out_has_orders       with out_valid high
//
// All orders live in one slot memory with a single read port, scanned one slot a cycle.
// Add to a full queue, or dispatch from an empty one: busy stays low.
// Add: busy up to the lowest free slot. Dispatch: busy over all slots, then S_DSP_DONE.
// The result is valid in the first cycle with busy low after the transfer.
// After reset the block clears the valid bits, one slot a cycle, busy until all are cleared.
// The receiver cannot stall; the result register is rewritten in the next cycle.
module urgency_fifo_priority_queue
  import ufpq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [15:0] in_tag,
  input  logic [15:0] in_item_ref,
  input  logic [15:0] in_address_ref,
  input  logic [1:0]  in_urgency,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [15:0] out_tag,
  output logic [15:0] out_item_ref,
  output logic [15:0] out_address_ref,
  output logic [1:0]  out_urgency,
  output logic        out_has_orders
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = $bits(slot_t);
  localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

  state_t state_r, state_nxt;

  logic [AW-1:0] clr_idx_r, clr_idx_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  logic          rd_done_r, rd_done_nxt;
  logic          dat_vld_r, dat_vld_nxt;
  logic [AW-1:0] dat_idx_r, dat_idx_nxt;
  logic [15:0]   id_r, id_nxt;
  logic [15:0]   item_r, item_nxt;
  logic [15:0]   adr_r, adr_nxt;
  logic [1:0]    urg_r, urg_nxt;
  logic          best_found_r, best_found_nxt;
  logic [AW-1:0] best_idx_r, best_idx_nxt;
  slot_t         best_r, best_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [31:0]   stamp_r, stamp_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [15:0]   out_id_r, out_id_nxt;
  logic [15:0]   out_item_r, out_item_nxt;
  logic [15:0]   out_adr_r, out_adr_nxt;
  logic [1:0]    out_urg_r, out_urg_nxt;
  logic          out_has_r, out_has_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  slot_t         ram_wslot;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [SW-1:0] ram_rdata;
  slot_t         rd_slot;

  logic [31:0]   stamp_diff;
  logic          rd_earlier;
  logic          rd_better;

  ufpq_ram #(
    .WIDTH(SW),
    .DEPTH(CAPACITY)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(SW'(ram_wslot)),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_slot = slot_t'(ram_rdata);

  // read slot is earlier than the current best when (best - read) mod 2^32 lies in (0, 2^31)
  assign stamp_diff = best_r.stamp - rd_slot.stamp;
  assign rd_earlier = (stamp_diff != 32'd0) && !stamp_diff[31];
  assign rd_better  = !best_found_r || (rd_slot.urgency > best_r.urgency) ||
                      ((rd_slot.urgency == best_r.urgency) && rd_earlier);

  assign busy = (state_r != S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (in_action == ACT_ADD && count_r != FULL_CNT) begin
            state_nxt = S_ADD_SCAN;
          end else if (in_action == ACT_DISPATCH && count_r != '0) begin
            state_nxt = S_DSP_SCAN;
          end
        end
      end
      S_ADD_SCAN: begin
        if (dat_vld_r && !rd_slot.valid) begin
          state_nxt = S_IDLE;
        end
      end
      S_DSP_SCAN: begin
        if (dat_vld_r && dat_idx_r == LAST_IDX) begin
          state_nxt = S_DSP_DONE;
        end
      end
      S_DSP_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    clr_idx_nxt    = clr_idx_r;
    rd_idx_nxt     = rd_idx_r;
    rd_done_nxt    = rd_done_r;
    dat_vld_nxt    = 1'b0;
    dat_idx_nxt    = dat_idx_r;
    id_nxt         = id_r;
    item_nxt       = item_r;
    adr_nxt        = adr_r;
    urg_nxt        = urg_r;
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    best_nxt       = best_r;
    count_nxt      = count_r;
    stamp_nxt      = stamp_r;

    out_valid_nxt  = 1'b0;
    out_status_nxt = STAT_ADDED;
    out_id_nxt     = '0;
    out_item_nxt   = '0;
    out_adr_nxt    = '0;
    out_urg_nxt    = '0;
    out_has_nxt    = (count_r != '0);

    ram_we    = 1'b0;
    ram_waddr = clr_idx_r;
    ram_wslot = '0;
    ram_re    = 1'b0;
    ram_raddr = rd_idx_r;

    // scan reads: one slot a cycle until the last has been issued
    if (state_r == S_ADD_SCAN || state_r == S_DSP_SCAN) begin
      ram_re      = !rd_done_r;
      dat_vld_nxt = !rd_done_r;
      dat_idx_nxt = rd_idx_r;
      if (!rd_done_r) begin
        rd_idx_nxt  = rd_idx_r + 1'b1;
        rd_done_nxt = (rd_idx_r == LAST_IDX);
      end
    end

    case (state_r)
      S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_idx_r;
        clr_idx_nxt = clr_idx_r + 1'b1;
      end
      S_IDLE: begin
        if (start) begin
          id_nxt         = in_tag;
          item_nxt       = in_item_ref;
          adr_nxt        = in_address_ref;
          urg_nxt        = in_urgency;
          rd_idx_nxt     = '0;
          rd_done_nxt    = 1'b0;
          best_found_nxt = 1'b0;
          if (in_action == ACT_ADD && count_r == FULL_CNT) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_FULL;
          end else if (in_action == ACT_DISPATCH && count_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_EMPTY;
          end
        end
      end
      S_ADD_SCAN: begin
        if (dat_vld_r && !rd_slot.valid) begin
          // lowest free slot found: store and stop reading
          ram_re                = 1'b0;
          dat_vld_nxt           = 1'b0;
          ram_we                = 1'b1;
          ram_waddr             = dat_idx_r;
          ram_wslot.valid       = 1'b1;
          ram_wslot.tag         = id_r;
          ram_wslot.item_ref    = item_r;
          ram_wslot.address_ref = adr_r;
          ram_wslot.urgency     = urg_r;
          ram_wslot.stamp       = stamp_r + 32'd1;
          stamp_nxt             = stamp_r + 32'd1;
          count_nxt             = count_r + 1'b1;
          out_valid_nxt         = 1'b1;
          out_status_nxt        = STAT_ADDED;
          out_has_nxt           = 1'b1;
        end
      end
      S_DSP_SCAN: begin
        if (dat_vld_r && rd_slot.valid && rd_better) begin
          best_found_nxt = 1'b1;
          best_idx_nxt   = dat_idx_r;
          best_nxt       = rd_slot;
        end
      end
      S_DSP_DONE: begin
        ram_we          = 1'b1;
        ram_waddr       = best_idx_r;
        ram_wslot       = best_r;
        ram_wslot.valid = 1'b0;
        count_nxt       = count_r - 1'b1;
        out_valid_nxt   = 1'b1;
        out_status_nxt  = STAT_DISPATCHED;
        out_id_nxt      = best_r.tag;
        out_item_nxt    = best_r.item_ref;
        out_adr_nxt     = best_r.address_ref;
        out_urg_nxt     = best_r.urgency;
        out_has_nxt     = (count_r != CW'(1));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_idx_r    <= '0;
      rd_done_r    <= 1'b0;
      dat_vld_r    <= 1'b0;
      best_found_r <= 1'b0;
      count_r      <= '0;
      stamp_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_idx_r    <= clr_idx_nxt;
      rd_done_r    <= rd_done_nxt;
      dat_vld_r    <= dat_vld_nxt;
      best_found_r <= best_found_nxt;
      count_r      <= count_nxt;
      stamp_r      <= stamp_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_idx_nxt;
    dat_idx_r    <= dat_idx_nxt;
    id_r         <= id_nxt;
    item_r       <= item_nxt;
    adr_r        <= adr_nxt;
    urg_r        <= urg_nxt;
    best_idx_r   <= best_idx_nxt;
    best_r       <= best_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_item_r   <= out_item_nxt;
    out_adr_r    <= out_adr_nxt;
    out_urg_r    <= out_urg_nxt;
    out_has_r    <= out_has_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_tag         = out_id_r;
  assign out_item_ref    = out_item_r;
  assign out_address_ref = out_adr_r;
  assign out_urgency     = out_urg_r;
  assign out_has_orders  = out_has_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above capacity");

  a_has_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_has_orders == (count_r != '0)))
    else $error("has_orders disagrees with entry count");

  a_dispatch_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STAT_DISPATCHED) |-> $past(state_r) == S_DSP_DONE)
    else $error("dispatch result without a completed scan");

  a_add_finds_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD_SCAN && dat_vld_r && dat_idx_r == LAST_IDX) |-> !rd_slot.valid)
    else $error("add scan ran past the last slot without a free entry");
`endif

endmodule

FILE: dv/order_queue_checker.sv
`timescale 1ns / 100ps

module order_queue_checker
  import ufpq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_action,
  input  logic [15:0] in_tag,
  input  logic [15:0] in_item_ref,
  input  logic [15:0] in_address_ref,
  input  logic [1:0]  in_urgency,
  input  logic        out_valid,
  input  logic [1:0]  out_status,
  input  logic [15:0] out_tag,
  input  logic [15:0] out_item_ref,
  input  logic [15:0] out_address_ref,
  input  logic [1:0]  out_urgency,
  input  logic        out_has_orders,
  output int          mismatches,
  output int          pending,
  output int          n_added,
  output int          n_dispatched,
  output int          n_empty,
  output int          n_full
);

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] tag;
    logic [15:0] item_ref;
    logic [15:0] address_ref;
    logic [1:0]  urgency;
    logic        has_orders;
  } order_result_t;

  slot_t         order_slots [CAPACITY];
  logic [31:0]   arrival_cnt;
  int unsigned   held_orders;
  order_result_t expected_results [$];
  order_result_t want;
  order_result_t seen;
  int            err_tally = 0;
  int            added_tally = 0;
  int            dispatched_tally = 0;
  int            empty_tally = 0;
  int            full_tally = 0;

  // Stamps wrap, so order them by the sign of the modular difference.
  function automatic logic stamp_before(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = b - a;
    return (d != 32'd0) && !d[31];
  endfunction

  function automatic order_result_t serve_request(logic act, logic [15:0] id,
                                                  logic [15:0] item, logic [15:0] addr,
                                                  logic [1:0] urg);
    order_result_t r;
    int            pick;
    r    = '0;
    pick = -1;
    if (act == ACT_ADD) begin
      for (int k = 0; k < CAPACITY; k++) begin
        if (!order_slots[k].valid) begin
          pick = k;
          break;
        end
      end
      if (pick < 0) begin
        r.status = STAT_FULL;
      end else begin
        arrival_cnt                   = arrival_cnt + 32'd1;
        order_slots[pick].valid       = 1'b1;
        order_slots[pick].tag         = id;
        order_slots[pick].item_ref    = item;
        order_slots[pick].address_ref = addr;
        order_slots[pick].urgency     = urg;
        order_slots[pick].stamp       = arrival_cnt;
        held_orders++;
        r.status = STAT_ADDED;
      end
    end else begin
      // Scan upward; a later slot wins only on strictly better rank.
      for (int k = 0; k < CAPACITY; k++) begin
        if (order_slots[k].valid) begin
          if (pick < 0) begin
            pick = k;
          end else if (order_slots[k].urgency > order_slots[pick].urgency) begin
            pick = k;
          end else if (order_slots[k].urgency == order_slots[pick].urgency &&
                       stamp_before(order_slots[k].stamp, order_slots[pick].stamp)) begin
            pick = k;
          end
        end
      end
      if (pick < 0) begin
        r.status = STAT_EMPTY;
      end else begin
        r.status                = STAT_DISPATCHED;
        r.tag                   = order_slots[pick].tag;
        r.item_ref              = order_slots[pick].item_ref;
        r.address_ref           = order_slots[pick].address_ref;
        r.urgency               = order_slots[pick].urgency;
        order_slots[pick].valid = 1'b0;
        if (held_orders > 0) held_orders--;
      end
    end
    r.has_orders = (held_orders != 0);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CAPACITY; k++) order_slots[k].valid = 1'b0;
      arrival_cnt = '0;
      held_orders = 0;
      expected_results.delete();
      mismatches   <= 0;
      pending      <= 0;
      n_added      <= 0;
      n_dispatched <= 0;
      n_empty      <= 0;
      n_full       <= 0;
    end else begin
      // Retire the result first; the item it belongs to was queued earlier.
      if (out_valid) begin
        seen.status      = out_status;
        seen.tag         = out_tag;
        seen.item_ref    = out_item_ref;
        seen.address_ref = out_address_ref;
        seen.urgency     = out_urgency;
        seen.has_orders  = out_has_orders;
        if (expected_results.size() == 0) begin
          err_tally++;
          if (err_tally <= 10)
            $display("[%0t] mismatch %0d: result with nothing expected: status=%0d tag=%h",
                     $realtime, err_tally, seen.status, seen.tag);
        end else begin
          want = expected_results.pop_front();
          if (want !== seen) begin
            err_tally++;
            if (err_tally <= 10) begin
              $display("[%0t] mismatch %0d: expected st=%0d tag=%h item=%h addr=%h urg=%0d m=%0b",
                       $realtime, err_tally,
                       want.status, want.tag, want.item_ref, want.address_ref,
                       want.urgency, want.has_orders);
              $display("[%0t] mismatch %0d: got      st=%0d tag=%h item=%h addr=%h urg=%0d m=%0b",
                       $realtime, err_tally,
                       seen.status, seen.tag, seen.item_ref, seen.address_ref,
                       seen.urgency, seen.has_orders);
            end
          end
        end
      end
      if (start && !busy) begin
        want = serve_request(in_action, in_tag, in_item_ref, in_address_ref,
                             in_urgency);
        case (want.status)
          STAT_ADDED:      added_tally++;
          STAT_DISPATCHED: dispatched_tally++;
          STAT_EMPTY:      empty_tally++;
          default:         full_tally++;
        endcase
        expected_results.push_back(want);
      end
      mismatches   <= err_tally;
      pending      <= expected_results.size();
      n_added      <= added_tally;
      n_dispatched <= dispatched_tally;
      n_empty      <= empty_tally;
      n_full       <= full_tally;
    end
  end

endmodule

FILE: dv/urgency_fifo_priority_queue_tb.sv
`timescale 1ns / 100ps

module urgency_fifo_priority_queue_tb
  import ufpq_pkg::*;
();

  localparam int CAPACITY = CAPACITY_DEF;
  localparam int N_ORDERS = 1450;

  typedef enum int {
    FILL_UP,
    DRAIN_OUT,
    MIXED
  } traffic_mode_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_action;
  logic [15:0] in_tag;
  logic [15:0] in_item_ref;
  logic [15:0] in_address_ref;
  logic [1:0]  in_urgency;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [15:0] out_tag;
  logic [15:0] out_item_ref;
  logic [15:0] out_address_ref;
  logic [1:0]  out_urgency;
  logic        out_has_orders;

  int mismatches;
  int pending;
  int n_added;
  int n_dispatched;
  int n_empty;
  int n_full;
  int issued = 0;

  urgency_fifo_priority_queue #(
    .CAPACITY(CAPACITY)
  ) uut (.*);

  order_queue_checker #(
    .CAPACITY(CAPACITY)
  ) order_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Hold the request until the block takes it; start stays high on return.
  task automatic issue_request(input logic act, input logic [15:0] id,
                               input logic [15:0] item, input logic [15:0] addr,
                               input logic [1:0] urg);
    start          <= 1'b1;
    in_action      <= act;
    in_tag         <= id;
    in_item_ref    <= item;
    in_address_ref <= addr;
    in_urgency     <= urg;
    @(posedge clk);
    while (busy) @(posedge clk);
    issued++;
  endtask

  task automatic pause_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_queue_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic int pick_gap(input logic quiet);
    if (quiet || $urandom_range(0, 99) >= 9) return 0;
    if ($urandom_range(0, 3) == 0) return $urandom_range(4, 80);
    return $urandom_range(1, 3);
  endfunction

  initial begin
    traffic_mode_t mode;
    int            block_len;
    logic          one_level;
    logic [1:0]    level;
    logic          act;
    int            gap;
    logic          mid_drain_done;

    start          = 1'b0;
    in_action      = ACT_ADD;
    in_tag         = '0;
    in_item_ref    = '0;
    in_address_ref = '0;
    in_urgency     = '0;
    rst_n          = 1'b0;
    mid_drain_done = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Empty dispatch with all data bits set, then a mix of levels and ties.
    issue_request(ACT_DISPATCH, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3);
    issue_request(ACT_ADD, 16'h0000, 16'h0000, 16'h0000, 2'd0);
    issue_request(ACT_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3);
    issue_request(ACT_ADD, 16'h1234, 16'h5678, 16'h9ABC, 2'd1);
    issue_request(ACT_ADD, 16'hA5A5, 16'h5A5A, 16'hC3C3, 2'd3);
    issue_request(ACT_ADD, 16'h0F0F, 16'hF0F0, 16'h3C3C, 2'd0);
    issue_request(ACT_ADD, 16'h8001, 16'h7FFE, 16'h4002, 2'd2);
    repeat (6) issue_request(ACT_DISPATCH, 16'($urandom), 16'($urandom), 16'($urandom),
                             2'($urandom_range(0, 3)));
    issue_request(ACT_DISPATCH, 16'h0000, 16'h0000, 16'h0000, 2'd0);
    // Refill a freed low slot with a later stamp; arrival order must still win.
    issue_request(ACT_ADD, 16'h0101, 16'h0202, 16'h0303, 2'd2);
    issue_request(ACT_ADD, 16'h0404, 16'h0505, 16'h0606, 2'd2);
    issue_request(ACT_ADD, 16'h0707, 16'h0808, 16'h0909, 2'd2);
    issue_request(ACT_DISPATCH, 16'hFFFF, 16'h0000, 16'hFFFF, 2'd1);
    issue_request(ACT_ADD, 16'h0A0A, 16'h0B0B, 16'h0C0C, 2'd2);
    repeat (3) issue_request(ACT_DISPATCH, 16'($urandom), 16'($urandom), 16'($urandom),
                             2'($urandom_range(0, 3)));
    wait_queue_drained();

    // Random traffic in blocks that lean toward filling, draining or neither.
    mode = FILL_UP;
    while (issued < N_ORDERS) begin
      block_len = (mode == FILL_UP && issued < 40) ? 80 : $urandom_range(40, 90);
      one_level = ($urandom_range(0, 3) == 0);
      level     = 2'($urandom_range(0, 3));
      if (!mid_drain_done && issued >= 600) begin
        wait_queue_drained();
        mid_drain_done = 1'b1;
      end
      for (int i = 0; i < block_len && issued < N_ORDERS; i++) begin
        case (mode)
          FILL_UP:   act = ($urandom_range(0, 99) < 95) ? ACT_ADD : ACT_DISPATCH;
          DRAIN_OUT: act = ($urandom_range(0, 99) < 95) ? ACT_DISPATCH : ACT_ADD;
          default:   act = $urandom_range(0, 1) ? ACT_DISPATCH : ACT_ADD;
        endcase
        gap = pick_gap(issued >= 600 && issued < 800);
        if (gap > 0) pause_cycles(gap);
        issue_request(act, 16'($urandom), 16'($urandom), 16'($urandom),
                      one_level ? level : 2'($urandom_range(0, 3)));
      end
      mode = traffic_mode_t'($urandom_range(0, 2));
    end

    wait_queue_drained();
    repeat (CAPACITY + 8) @(posedge clk);

    $display("Run covered %0d transfers: %0d orders stored, %0d dispatched,", issued,
             n_added, n_dispatched);
    $display("%0d dispatches from an empty queue, %0d adds refused on a full queue",
             n_empty, n_full);
    if (pending != 0)
      $display("%0d expected results never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
